@@ rtl/vfao_pkg.sv @@
`default_nettype none

package vfao_pkg;

  localparam int CHUNK_EDGE  = 16;
  localparam int COORD_W     = 4;
  localparam int MASK_W      = 27;
  localparam int DIR_W       = 3;
  localparam int OCCL_W      = 2;
  localparam int NUM_FACES   = 6;
  localparam int NUM_CORNERS = 4;
  localparam int CENTRE_BIT  = 13;
  localparam int CELL_W      = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // Corner selectors for the side and corner cells of one face corner
  localparam int SEL_SIDE1  = 0;
  localparam int SEL_SIDE2  = 1;
  localparam int SEL_CORNER = 2;

  // Unit-cell corner positions of each face quad, in face order +x,+y,+z,-x,-y,-z
  localparam bit QUAD_CORNER [NUM_FACES][NUM_CORNERS][3] = '{
    '{'{1, 0, 1}, '{1, 0, 0}, '{1, 1, 0}, '{1, 1, 1}},
    '{'{0, 1, 1}, '{1, 1, 1}, '{1, 1, 0}, '{0, 1, 0}},
    '{'{0, 0, 1}, '{1, 0, 1}, '{1, 1, 1}, '{0, 1, 1}},
    '{'{0, 0, 0}, '{0, 0, 1}, '{0, 1, 1}, '{0, 1, 0}},
    '{'{0, 0, 0}, '{1, 0, 0}, '{1, 0, 1}, '{0, 0, 1}},
    '{'{1, 0, 0}, '{0, 0, 0}, '{0, 1, 0}, '{1, 1, 0}}
  };

  // One result item, x in the lowest bits
  typedef struct packed {
    logic                                  diag_flip;
    logic [NUM_CORNERS-1:0][OCCL_W-1:0]    occl;
    logic [DIR_W-1:0]                      face_dir;
    logic [COORD_W-1:0]                    out_z;
    logic [COORD_W-1:0]                    out_y;
    logic [COORD_W-1:0]                    out_x;
  } out_item_t;

  // Normal offset of face d along axis a
  function automatic int normal_off(int d, int a);
    int axis;
    int sgn;
    axis = (d < 3) ? d : d - 3;
    sgn  = (d < 3) ? 1 : -1;
    return (axis == a) ? sgn : 0;
  endfunction

  // Mask bit of the cell at offset (ox, oy, oz)
  function automatic logic [CELL_W-1:0] cell_bit(int ox, int oy, int oz);
    return CELL_W'((ox + 1) * 9 + (oy + 1) * 3 + (oz + 1));
  endfunction

  // Mask bit of the air neighbour in front of face d
  function automatic logic [CELL_W-1:0] face_cell(int d);
    return cell_bit(normal_off(d, 0), normal_off(d, 1), normal_off(d, 2));
  endfunction

  // Mask bit of side one, side two or the corner cell of corner k on face d
  function automatic logic [CELL_W-1:0] corner_cell(int d, int k, int sel);
    int off [3];
    int axis;
    int n;
    int s;
    axis = 0;
    for (int a = 0; a < 3; a++) begin
      n = normal_off(d, a);
      off[a] = n;
      if (n == 0) begin
        s = QUAD_CORNER[d][k][a] ? 1 : -1;
        if (sel == SEL_CORNER || (sel == SEL_SIDE1 && axis == 0) ||
            (sel == SEL_SIDE2 && axis == 1)) begin
          off[a] = off[a] + s;
        end
        axis++;
      end
    end
    return cell_bit(off[0], off[1], off[2]);
  endfunction

  // Occlusion level from two sides and a corner, 3 is fully lit
  function automatic logic [OCCL_W-1:0] occl_level(logic s1, logic s2, logic c);
    logic [OCCL_W-1:0] cnt;
    cnt = OCCL_W'(s1) + OCCL_W'(s2) + OCCL_W'(c);
    return (s1 && s2) ? '0 : OCCL_W'(3) - cnt;
  endfunction

endpackage

`default_nettype wire

@@ rtl/vfao_face_unit.sv @@
`default_nettype none

module vfao_face_unit (
  input  wire logic [vfao_pkg::MASK_W-1:0]                          mask,
  input  wire logic [vfao_pkg::DIR_W-1:0]                           face_dir,
  output logic [vfao_pkg::NUM_CORNERS-1:0][vfao_pkg::OCCL_W-1:0]    occl,
  output logic                                                      diag_flip
);
  import vfao_pkg::*;

  logic [NUM_FACES-1:0][NUM_CORNERS-1:0][OCCL_W-1:0] lvl;
  logic [OCCL_W:0] sum_02;
  logic [OCCL_W:0] sum_13;

  // Form every corner level of every face from fixed mask taps
  for (genvar d = 0; d < NUM_FACES; d++) begin : g_face
    for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
      localparam logic [CELL_W-1:0] B1 = corner_cell(d, k, SEL_SIDE1);
      localparam logic [CELL_W-1:0] B2 = corner_cell(d, k, SEL_SIDE2);
      localparam logic [CELL_W-1:0] BC = corner_cell(d, k, SEL_CORNER);
      assign lvl[d][k] = occl_level(mask[B1], mask[B2], mask[BC]);
    end
  end

  // Select the levels of the requested face
  always_comb begin
    occl = lvl[0];
    for (int d = 1; d < NUM_FACES; d++) begin
      if (face_dir == DIR_W'(d)) begin
        occl = lvl[d];
      end
    end
  end

  // Flip the quad diagonal when corners 0 and 2 are at least as bright as 1 and 3
  assign sum_02    = {1'b0, occl[0]} + {1'b0, occl[2]};
  assign sum_13    = {1'b0, occl[1]} + {1'b0, occl[3]};
  assign diag_flip = (sum_02 >= sum_13);

endmodule

`default_nettype wire

@@ rtl/voxel_face_cull_ambient_occlusion_top.sv @@
// A voxel's face results pass through the hold registers, then the result register.
// One face result per cycle while the output is not stalled; a voxel holds the face
//   sequencer until its last exposed face is emitted, and the next voxel is taken in that same cycle.
// Voxels with an air centre or no exposed face are absorbed without any face result.
// Reset (rst_n low, synchronous) clears the sequencer and output valid flags.
`default_nettype none

module voxel_face_cull_ambient_occlusion_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // voxel_x[3:0], voxel_y[7:4], voxel_z[11:8], neighbour_solid[38:12], zero[39]
  input  wire logic [vfao_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // out_x[3:0], out_y[7:4], out_z[11:8], face_dir[14:12], occl_0[16:15],
  // occl_1[18:17], occl_2[20:19], occl_3[22:21], diag_flip[23]
  output logic [vfao_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                    out_tlast
);
  import vfao_pkg::*;

  logic [COORD_W-1:0]   in_x;
  logic [COORD_W-1:0]   in_y;
  logic [COORD_W-1:0]   in_z;
  logic [MASK_W-1:0]    in_mask;
  logic [NUM_FACES-1:0] in_exposed;
  logic                 in_xfer;

  logic                 hold_vld_r, hold_vld_nxt;
  logic [NUM_FACES-1:0] pend_r, pend_nxt;
  logic [COORD_W-1:0]   hold_x_r, hold_y_r, hold_z_r;
  logic [MASK_W-1:0]    hold_mask_r;

  logic [DIR_W-1:0]     cur_dir;
  logic [NUM_FACES-1:0] cur_onehot;
  logic [NUM_FACES-1:0] remaining;
  logic                 emit;

  logic [NUM_CORNERS-1:0][OCCL_W-1:0] cur_occl;
  logic                 cur_flip;

  logic                 out_vld_r, out_vld_nxt;
  out_item_t            out_data_r;
  logic                 out_last_r;

  // Unpack the input transfer
  assign in_x    = COORD_W'(in_tdata[COORD_W-1:0] % CHUNK_EDGE);
  assign in_y    = COORD_W'(in_tdata[2*COORD_W-1:COORD_W] % CHUNK_EDGE);
  assign in_z    = COORD_W'(in_tdata[3*COORD_W-1:2*COORD_W] % CHUNK_EDGE);
  assign in_mask = in_tdata[3*COORD_W+MASK_W-1:3*COORD_W];

  // Mark faces whose neighbour is air, none when the centre is air
  always_comb begin
    for (int d = 0; d < NUM_FACES; d++) begin
      in_exposed[d] = in_mask[CENTRE_BIT] & ~in_mask[face_cell(d)];
    end
  end

  // Pick the lowest pending face
  always_comb begin
    cur_dir    = '0;
    cur_onehot = '0;
    for (int d = NUM_FACES - 1; d >= 0; d--) begin
      if (pend_r[d]) begin
        cur_dir    = DIR_W'(d);
        cur_onehot = NUM_FACES'(1) << d;
      end
    end
  end

  assign remaining = pend_r & ~cur_onehot;
  assign emit      = hold_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !hold_vld_r || (emit && (remaining == '0));
  assign in_xfer   = in_tvalid && in_tready;

  vfao_face_unit u_face (
    .mask      (hold_mask_r),
    .face_dir  (cur_dir),
    .occl      (cur_occl),
    .diag_flip (cur_flip)
  );

  // Advance the face sequencer
  always_comb begin
    hold_vld_nxt = hold_vld_r;
    pend_nxt     = pend_r;
    if (in_xfer) begin
      hold_vld_nxt = |in_exposed;
      pend_nxt     = in_exposed;
    end else if (emit) begin
      hold_vld_nxt = |remaining;
      pend_nxt     = remaining;
    end
  end

  // Drop the output valid once taken, raise it on each face
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      pend_r     <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      pend_r     <= pend_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Hold the voxel being worked on
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold_x_r    <= in_x;
      hold_y_r    <= in_y;
      hold_z_r    <= in_z;
      hold_mask_r <= in_mask;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.out_x     <= hold_x_r;
      out_data_r.out_y     <= hold_y_r;
      out_data_r.out_z     <= hold_z_r;
      out_data_r.face_dir  <= cur_dir;
      out_data_r.occl      <= cur_occl;
      out_data_r.diag_flip <= cur_flip;
      out_last_r           <= (remaining == '0);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
module tb;

  localparam int NUM_AXES     = 3;
  localparam int NUM_CORNERS  = 4;
  localparam int MAX_LEVEL    = 3;
  localparam int NUM_RANDOM   = 380;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 8;
  localparam int CENTRE       = vfao_pkg::CENTRE_BIT;

  typedef enum logic [2:0] {
    FACE_POS_X, FACE_POS_Y, FACE_POS_Z, FACE_NEG_X, FACE_NEG_Y, FACE_NEG_Z, FACE_COUNT
  } face_e;

  typedef enum int {RX_STEADY, RX_LIGHT, RX_HEAVY} rx_mode_e;

  // Quad corner positions per face, written as (x, y, z) with x in bit 0 of [0:2]
  localparam logic [0:2] CORNER_POS [6][NUM_CORNERS] = '{
    '{3'b101, 3'b100, 3'b110, 3'b111},
    '{3'b011, 3'b111, 3'b110, 3'b010},
    '{3'b001, 3'b101, 3'b111, 3'b011},
    '{3'b000, 3'b001, 3'b011, 3'b010},
    '{3'b000, 3'b100, 3'b101, 3'b001},
    '{3'b100, 3'b000, 3'b010, 3'b110}
  };

  typedef struct {
    logic [3:0]                   x;
    logic [3:0]                   y;
    logic [3:0]                   z;
    logic [vfao_pkg::MASK_W-1:0]  solid;
    int                           gap;
    bit                           drain;
  } voxel_t;

  typedef struct packed {
    logic [3:0]       x;
    logic [3:0]       y;
    logic [3:0]       z;
    logic [2:0]       dir;
    logic [3:0][1:0]  occl;
    logic             flip;
    logic             last;
  } face_res_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic [vfao_pkg::IN_TDATA_W-1:0]   in_tdata = '0;
  logic                              out_tready = 1'b0;
  logic                              in_tready;
  logic                              out_tvalid;
  logic [vfao_pkg::OUT_TDATA_W-1:0]  out_tdata;
  logic                              out_tlast;

  voxel_t     voxel_queue[$];
  face_res_t  pending_faces[$];
  voxel_t     in_flight;
  int         send_gap = 0;
  bit         feeding_done = 1'b0;
  int         stall_left = 0;
  rx_mode_e   rx_mode = RX_STEADY;
  int         idle_cycles = 0;
  int         cycle_count = 0;
  int         errors = 0;

  voxel_face_cull_ambient_occlusion_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int cell_index(int ox, int oy, int oz);
    return (ox + 1) * 9 + (oy + 1) * 3 + (oz + 1);
  endfunction

  function automatic int face_normal(int f, int a);
    return (a == f % NUM_AXES) ? ((f < FACE_NEG_X) ? 1 : -1) : 0;
  endfunction

  // Cells whose offset has exactly nz non-zero components
  function automatic logic [vfao_pkg::MASK_W-1:0] shell_mask(int nz);
    logic [vfao_pkg::MASK_W-1:0] m;
    m = '0;
    for (int ox = -1; ox <= 1; ox++)
      for (int oy = -1; oy <= 1; oy++)
        for (int oz = -1; oz <= 1; oz++)
          if ((ox != 0) + (oy != 0) + (oz != 0) == nz) m[cell_index(ox, oy, oz)] = 1'b1;
    return m;
  endfunction

  // Cells lying in one plane of the neighbourhood
  function automatic logic [vfao_pkg::MASK_W-1:0] plane_mask(int axis, int off);
    logic [vfao_pkg::MASK_W-1:0] m;
    int o[3];
    m = '0;
    for (int ox = -1; ox <= 1; ox++)
      for (int oy = -1; oy <= 1; oy++)
        for (int oz = -1; oz <= 1; oz++) begin
          o[0] = ox;
          o[1] = oy;
          o[2] = oz;
          if (o[axis] == off) m[cell_index(ox, oy, oz)] = 1'b1;
        end
    return m;
  endfunction

  // Mostly short pauses, now and then a long one
  function automatic int pick_pause();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  function automatic int next_gap(bit calm);
    if (calm || $urandom_range(0, 99) < 55) return 0;
    return pick_pause();
  endfunction

  task automatic add_voxel(int x, int y, int z, logic [vfao_pkg::MASK_W-1:0] m, bit drain);
    voxel_t v;
    v.x     = 4'(x);
    v.y     = 4'(y);
    v.z     = 4'(z);
    v.solid = m;
    v.gap   = next_gap(1'b0);
    v.drain = drain;
    voxel_queue = {voxel_queue, v};
  endtask

  // Work out the face results of one voxel and queue them in emission order
  function automatic void predict_faces(voxel_t v);
    face_res_t  r;
    face_res_t  batch[$];
    int         n[3];
    int         p1[3];
    int         p2[3];
    int         pc[3];
    int         t;
    int         s;
    int         cnt;
    bit         s1;
    bit         s2;
    bit         c;
    logic [1:0] lv[NUM_CORNERS];
    if (!v.solid[CENTRE]) return;
    for (int f = 0; f < FACE_COUNT; f++) begin
      for (int a = 0; a < NUM_AXES; a++) n[a] = face_normal(f, a);
      if (v.solid[cell_index(n[0], n[1], n[2])]) continue;
      for (int k = 0; k < NUM_CORNERS; k++) begin
        p1 = n;
        p2 = n;
        pc = n;
        t  = 0;
        for (int a = 0; a < NUM_AXES; a++) begin
          if (n[a] == 0) begin
            s = CORNER_POS[f][k][a] ? 1 : -1;
            if (t == 0) p1[a] += s;
            else p2[a] += s;
            pc[a] += s;
            t++;
          end
        end
        s1  = v.solid[cell_index(p1[0], p1[1], p1[2])];
        s2  = v.solid[cell_index(p2[0], p2[1], p2[2])];
        c   = v.solid[cell_index(pc[0], pc[1], pc[2])];
        cnt = int'(s1) + int'(s2) + int'(c);
        lv[k] = (s1 && s2) ? 2'd0 : 2'(MAX_LEVEL - cnt);
      end
      r.x    = v.x;
      r.y    = v.y;
      r.z    = v.z;
      r.dir  = 3'(f);
      for (int k = 0; k < NUM_CORNERS; k++) r.occl[k] = lv[k];
      r.flip = (int'(lv[0]) + int'(lv[2]) >= int'(lv[1]) + int'(lv[3]));
      r.last = 1'b0;
      batch = {batch, r};
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    pending_faces = {pending_faces, batch};
  endfunction

  function automatic void compare_field(string name, logic [3:0] e, logic [3:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      errors++;
    end
  endfunction

  task automatic check_face(face_res_t e, vfao_pkg::out_item_t g, logic last);
    compare_field("out_x", e.x, g.out_x);
    compare_field("out_y", e.y, g.out_y);
    compare_field("out_z", e.z, g.out_z);
    compare_field("face_dir", 4'(e.dir), 4'(g.face_dir));
    for (int k = 0; k < NUM_CORNERS; k++)
      compare_field($sformatf("occl_%0d", k), 4'(e.occl[k]), 4'(g.occl[k]));
    compare_field("diag_flip", 4'(e.flip), 4'(g.diag_flip));
    compare_field("last_face", 4'(e.last), 4'(last));
  endtask

  // Driver: present queued voxels, predict on each input transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid    <= 1'b0;
      send_gap     <= 0;
      feeding_done <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_faces(in_flight);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          in_tvalid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (voxel_queue.size() == 0) begin
          in_tvalid    <= 1'b0;
          feeding_done <= 1'b1;
        end else if (voxel_queue[0].drain && pending_faces.size() != 0) begin
          // hold off until every outstanding face has been seen
          in_tvalid <= 1'b0;
        end else begin
          in_flight = voxel_queue.pop_front();
          in_tdata  <= vfao_pkg::IN_TDATA_W'({in_flight.solid, in_flight.z,
                                              in_flight.y, in_flight.x});
          in_tvalid <= 1'b1;
          send_gap  <= in_flight.gap;
        end
      end
    end
  end

  // Monitor: check each output transfer, stall the result side at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_faces.size() == 0) begin
          $display("%0t: unexpected face result, expected none, got tdata %h tlast %b",
                   $time, out_tdata, out_tlast);
          errors++;
        end else begin
          check_face(pending_faces.pop_front(), out_tdata, out_tlast);
        end
      end
      if (cycle_count % 256 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 2));
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_tready <= 1'b1;
        if (rx_mode != RX_STEADY &&
            $urandom_range(0, 99) < ((rx_mode == RX_LIGHT) ? 15 : 45))
          stall_left <= pick_pause();
      end
    end
  end

  // Count cycles without any transfer
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    logic [vfao_pkg::MASK_W-1:0] all_solid;
    logic [vfao_pkg::MASK_W-1:0] centre_only;
    logic [vfao_pkg::MASK_W-1:0] m;
    voxel_t v;
    bit calm;

    all_solid   = '1;
    centre_only = '0;
    centre_only[CENTRE] = 1'b1;

    // Directed: air centre, lone voxel, full enclosure, single open faces
    add_voxel(0, 0, 0, '0, 1'b0);
    add_voxel(15, 15, 15, all_solid & ~centre_only, 1'b0);
    add_voxel(0, 0, 0, centre_only, 1'b0);
    add_voxel(15, 15, 15, all_solid, 1'b1);
    for (int f = 0; f < FACE_COUNT; f++) begin
      m = all_solid;
      m[cell_index(face_normal(f, 0), face_normal(f, 1), face_normal(f, 2))] = 1'b0;
      add_voxel(f * 3, 15 - f * 2, f, m, 1'b0);
    end
    // Corners only, edges only, faces open with edges solid
    add_voxel(5, 10, 5, centre_only | shell_mask(3), 1'b0);
    add_voxel(10, 5, 10, centre_only | shell_mask(2), 1'b0);
    add_voxel(15, 0, 15, all_solid & ~shell_mask(1), 1'b0);
    // Lopsided neighbourhoods for mixed levels and both diagonals
    add_voxel(0, 15, 3, centre_only | plane_mask(1, 1), 1'b0);
    add_voxel(12, 3, 15, centre_only | plane_mask(0, -1), 1'b0);
    add_voxel(9, 6, 0, centre_only | plane_mask(2, 1), 1'b0);
    add_voxel(3, 12, 7, (centre_only | plane_mask(0, 1)) & ~plane_mask(2, -1), 1'b0);

    // Random voxels of varying density, mostly with a solid centre
    for (int i = 0; i < NUM_RANDOM; i++) begin
      calm = ((i / 40) % 3 == 1);
      v.x = 4'($urandom);
      v.y = 4'($urandom);
      v.z = 4'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        v.solid = vfao_pkg::MASK_W'($urandom);
      end else begin
        m = '0;
        for (int b = 0; b < vfao_pkg::MASK_W; b++) m[b] = ($urandom_range(0, 99) < 50);
        v.solid = m;
        m = '0;
        for (int b = 0; b < vfao_pkg::MASK_W; b++)
          m[b] = ($urandom_range(0, 99) < $urandom_range(5, 95));
        v.solid = m;
      end
      if ($urandom_range(0, 99) < 85) v.solid[CENTRE] = 1'b1;
      v.gap   = next_gap(calm);
      v.drain = (i % 120 == 60);
      voxel_queue = {voxel_queue, v};
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (!(feeding_done && pending_faces.size() == 0) && idle_cycles < IDLE_LIMIT)
      @(posedge clk);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      errors++;
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
    end
    if (pending_faces.size() != 0) begin
      $display("%0t: %0d face results never arrived", $time, pending_faces.size());
      errors++;
    end
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/vfao_pkg.sv
rtl/vfao_face_unit.sv
rtl/voxel_face_cull_ambient_occlusion_top.sv
bench/tb.sv
